[hdl/occ_pkg.sv]
`default_nettype none
package occ_pkg;

	// Limits of the tree
	localparam int MAX_LEVEL    = 10;
	localparam int MAX_BASE_LOG = 6;

	// Field widths
	localparam int LEVEL_W = 4;
	localparam int IDX_W   = 42;
	localparam int COORD_W = 16;
	localparam int LOG_W   = 3;
	localparam int DIMS_W  = 2;
	localparam int CFG_IDX_W = 2;

	// Widest intermediate index: three base logs plus three bits per level
	localparam int WIDE_W = 3 * MAX_BASE_LOG + 3 * MAX_LEVEL;
	localparam int SHAMT_W = $clog2(WIDE_W + 1);

	// Stream packing
	localparam int IN_BITS     = LEVEL_W + IDX_W + 3 * COORD_W;
	localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = IDX_W + 3 * COORD_W;
	localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

	// Dimension code that selects 3D; every other code acts as 2D
	localparam logic [DIMS_W-1:0] DIMS_3D = DIMS_W'(3);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIMS       = 2'd0,
		CFG_BASE_LOG_X = 2'd1,
		CFG_BASE_LOG_Y = 2'd2,
		CFG_BASE_LOG_Z = 2'd3
	} cfg_reg_t;

	// Request kinds
	typedef enum logic {
		REQ_INDEX_TO_COORD = 1'b0,
		REQ_COORD_TO_INDEX = 1'b1
	} req_t;

	// Effective grid shape after saturation and 2D folding
	typedef struct packed {
		logic             three;
		logic [LOG_W-1:0] bx;
		logic [LOG_W-1:0] by;
		logic [LOG_W-1:0] bz;
	} geom_t;

	// One result item
	typedef struct packed {
		logic               oor;
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
		logic [IDX_W-1:0]   index;
	} res_t;

	function automatic logic [LOG_W-1:0] sat_log(input logic [LOG_W-1:0] v);
		logic [LOG_W-1:0] lim;
		lim = LOG_W'(MAX_BASE_LOG);
		return (v > lim) ? lim : v;
	endfunction

endpackage
`default_nettype wire

[hdl/occ_decode.sv]
`default_nettype none
module occ_decode (
	input  wire occ_pkg::geom_t                  geom,
	input  wire logic [occ_pkg::LEVEL_W-1:0]    level,
	input  wire logic [occ_pkg::IDX_W-1:0]      cell_index,
	output occ_pkg::res_t                        res
);

	// Index to coordinates: split base number and Morton digits
	always_comb begin
		logic [occ_pkg::SHAMT_W-1:0] lev_w;
		logic [occ_pkg::SHAMT_W-1:0] mbits;
		logic [occ_pkg::SHAMT_W:0]   tbits;
		logic [occ_pkg::IDX_W-1:0]   base;
		logic [occ_pkg::IDX_W-1:0]   bsx;
		logic [occ_pkg::IDX_W-1:0]   bsy;
		logic [occ_pkg::IDX_W-1:0]   bsz;
		logic [occ_pkg::COORD_W-1:0] xm;
		logic [occ_pkg::COORD_W-1:0] ym;
		logic [occ_pkg::COORD_W-1:0] zm;
		logic                        bad;

		lev_w = occ_pkg::SHAMT_W'(level);
		mbits = geom.three ? (lev_w + (lev_w << 1)) : (lev_w << 1);
		tbits = (occ_pkg::SHAMT_W + 1)'(geom.bx) + (occ_pkg::SHAMT_W + 1)'(geom.by)
			+ (occ_pkg::SHAMT_W + 1)'(geom.bz) + (occ_pkg::SHAMT_W + 1)'(mbits);

		bad = (level > occ_pkg::LEVEL_W'(occ_pkg::MAX_LEVEL))
			|| ((tbits < (occ_pkg::SHAMT_W + 1)'(occ_pkg::IDX_W))
				&& ((cell_index >> tbits) != '0));

		// Base cell part, row-major with x fastest
		base = cell_index >> mbits;
		bsx  = base & ~({occ_pkg::IDX_W{1'b1}} << geom.bx);
		bsy  = (base >> geom.bx) & ~({occ_pkg::IDX_W{1'b1}} << geom.by);
		bsz  = base >> (occ_pkg::SHAMT_W'(geom.bx) + occ_pkg::SHAMT_W'(geom.by));

		// Deinterleave the Morton digits
		xm = '0;
		ym = '0;
		zm = '0;
		for (int b = 0; b < occ_pkg::MAX_LEVEL; b++) begin
			if (b < int'(level)) begin
				if (geom.three) begin
					xm[b] = cell_index[3*b];
					ym[b] = cell_index[3*b+1];
					zm[b] = cell_index[3*b+2];
				end else begin
					xm[b] = cell_index[2*b];
					ym[b] = cell_index[2*b+1];
				end
			end
		end

		res.index = '0;
		res.oor   = bad;
		if (bad) begin
			res.x = '0;
			res.y = '0;
			res.z = '0;
		end else begin
			res.x = (occ_pkg::COORD_W'(bsx) << level) | xm;
			res.y = (occ_pkg::COORD_W'(bsy) << level) | ym;
			res.z = geom.three ? ((occ_pkg::COORD_W'(bsz) << level) | zm) : '0;
		end
	end

endmodule
`default_nettype wire

[hdl/occ_encode.sv]
`default_nettype none
module occ_encode (
	input  wire occ_pkg::geom_t                  geom,
	input  wire logic [occ_pkg::LEVEL_W-1:0]    level,
	input  wire logic [occ_pkg::COORD_W-1:0]    coord_x,
	input  wire logic [occ_pkg::COORD_W-1:0]    coord_y,
	input  wire logic [occ_pkg::COORD_W-1:0]    coord_z,
	output occ_pkg::res_t                        res
);

	// Coordinates to index: range check, base number, Morton interleave
	always_comb begin
		logic [occ_pkg::SHAMT_W-1:0] lev_w;
		logic [occ_pkg::SHAMT_W-1:0] mbits;
		logic [occ_pkg::COORD_W-1:0] zc;
		logic [occ_pkg::WIDE_W-1:0]  base;
		logic [occ_pkg::WIDE_W-1:0]  m3;
		logic [occ_pkg::WIDE_W-1:0]  m2;
		logic [occ_pkg::WIDE_W-1:0]  wide;
		logic                        bad;

		lev_w = occ_pkg::SHAMT_W'(level);
		mbits = geom.three ? (lev_w + (lev_w << 1)) : (lev_w << 1);
		zc    = geom.three ? coord_z : '0;

		bad = (level > occ_pkg::LEVEL_W'(occ_pkg::MAX_LEVEL))
			|| ((coord_x >> (lev_w + occ_pkg::SHAMT_W'(geom.bx))) != '0)
			|| ((coord_y >> (lev_w + occ_pkg::SHAMT_W'(geom.by))) != '0)
			|| ((zc >> (lev_w + occ_pkg::SHAMT_W'(geom.bz))) != '0);

		base = occ_pkg::WIDE_W'(coord_x >> level)
			| (occ_pkg::WIDE_W'(coord_y >> level) << geom.bx)
			| (occ_pkg::WIDE_W'(zc >> level)
				<< (occ_pkg::SHAMT_W'(geom.bx) + occ_pkg::SHAMT_W'(geom.by)));

		// Interleave the low bits, x in digit bit 0
		m3 = '0;
		m2 = '0;
		for (int b = 0; b < occ_pkg::MAX_LEVEL; b++) begin
			if (b < int'(level)) begin
				m3[3*b]   = coord_x[b];
				m3[3*b+1] = coord_y[b];
				m3[3*b+2] = zc[b];
				m2[2*b]   = coord_x[b];
				m2[2*b+1] = coord_y[b];
			end
		end

		wide = (base << mbits) | (geom.three ? m3 : m2);
		bad  = bad || (wide[occ_pkg::WIDE_W-1:occ_pkg::IDX_W] != '0);

		res.x     = '0;
		res.y     = '0;
		res.z     = '0;
		res.oor   = bad;
		res.index = bad ? '0 : wide[occ_pkg::IDX_W-1:0];
	end

endmodule
`default_nettype wire

[hdl/octree_cell_index_coordinate_map.sv]
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tdata: level, cell_index, coord_x/y/z; tuser: req_type
// m_       out  m_tvalid/m_tready  tdata: index_out, x/y/z_out; tuser: out_of_range
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// An input transfer goes through the input register and the result register to m_.
// One item per cycle is sustained while m_tready is high; the decode and encode
// logic sits between the input register and the result register.
// arst_n clears both stage valid bits and loads dims=3, base logs=0.
// A stall on m_ backs up into the input register; s_tready drops only
// when both stages are full.
`default_nettype none
module octree_cell_index_coordinate_map (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// level, cell_index, coord_x, coord_y, coord_z, zero pad
	input  wire logic [occ_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type
	input  wire logic                               s_tuser,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	// index_out, x_out, y_out, z_out, zero pad
	output      logic [occ_pkg::OUT_DATA_W-1:0]    m_tdata,
	// out_of_range
	output      logic                               m_tuser,
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [occ_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [occ_pkg::LOG_W-1:0]         cfg_data
);

	localparam int LW = occ_pkg::LEVEL_W;
	localparam int IW = occ_pkg::IDX_W;
	localparam int CW = occ_pkg::COORD_W;

	logic [occ_pkg::DIMS_W-1:0] dims_q;
	logic [occ_pkg::LOG_W-1:0]  blx_q;
	logic [occ_pkg::LOG_W-1:0]  bly_q;
	logic [occ_pkg::LOG_W-1:0]  blz_q;
	occ_pkg::geom_t             geom;

	logic                       v_s1;
	occ_pkg::req_t              req_s1;
	logic [LW-1:0]              level_s1;
	logic [IW-1:0]              index_s1;
	logic [CW-1:0]              x_s1;
	logic [CW-1:0]              y_s1;
	logic [CW-1:0]              z_s1;
	logic                       adv_s1;

	occ_pkg::res_t              dec_res;
	occ_pkg::res_t              enc_res;
	logic                       v_s2;
	occ_pkg::res_t              res_s2;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= occ_pkg::DIMS_3D;
			blx_q  <= '0;
			bly_q  <= '0;
			blz_q  <= '0;
		end else if (cfg_valid) begin
			case (occ_pkg::cfg_reg_t'(cfg_index))
				occ_pkg::CFG_DIMS:       dims_q <= cfg_data[occ_pkg::DIMS_W-1:0];
				occ_pkg::CFG_BASE_LOG_X: blx_q  <= cfg_data;
				occ_pkg::CFG_BASE_LOG_Y: bly_q  <= cfg_data;
				occ_pkg::CFG_BASE_LOG_Z: blz_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective grid shape
	always_comb begin
		geom.three = (dims_q == occ_pkg::DIMS_3D);
		geom.bx    = occ_pkg::sat_log(blx_q);
		geom.by    = occ_pkg::sat_log(bly_q);
		geom.bz    = geom.three ? occ_pkg::sat_log(blz_q) : '0;
	end

	// Stage handshake
	assign adv_s1   = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (adv_s1)
				v_s2 <= v_s1;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1   <= occ_pkg::req_t'(s_tuser);
			level_s1 <= s_tdata[LW-1:0];
			index_s1 <= s_tdata[LW+IW-1:LW];
			x_s1     <= s_tdata[LW+IW+CW-1:LW+IW];
			y_s1     <= s_tdata[LW+IW+2*CW-1:LW+IW+CW];
			z_s1     <= s_tdata[LW+IW+3*CW-1:LW+IW+2*CW];
		end
	end

	occ_decode u_decode (
		.geom       (geom),
		.level      (level_s1),
		.cell_index (index_s1),
		.res        (dec_res)
	);

	occ_encode u_encode (
		.geom    (geom),
		.level   (level_s1),
		.coord_x (x_s1),
		.coord_y (y_s1),
		.coord_z (z_s1),
		.res     (enc_res)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s1 && v_s1)
			res_s2 <= (req_s1 == occ_pkg::REQ_COORD_TO_INDEX) ? enc_res : dec_res;
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = res_s2.oor;
	assign m_tdata  = {{(occ_pkg::OUT_DATA_W - occ_pkg::OUT_BITS){1'b0}},
		res_s2.z, res_s2.y, res_s2.x, res_s2.index};

endmodule
`default_nettype wire

[hdl/occ_checker.sv]
`default_nettype none
module occ_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic [occ_pkg::IN_DATA_W-1:0]   s_tdata,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic [occ_pkg::OUT_DATA_W-1:0]  m_tdata,
	input wire logic                             m_tuser,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready
);

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An out-of-range result carries all-zero fields
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out-of-range result with nonzero fields");

	// A level beyond the tree depth comes out flagged, unless a stall on m_ holds it back
	a_level_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 2) && $past(arst_n, 1) && $past(s_tvalid && s_tready, 2)
		&& ($past(s_tdata[occ_pkg::LEVEL_W-1:0], 2)
			> occ_pkg::LEVEL_W'(occ_pkg::MAX_LEVEL))
		&& $past(m_tready, 1)
		|-> m_tvalid && m_tuser)
		else $error("level beyond depth not flagged");

endmodule

bind octree_cell_index_coordinate_map occ_checker u_occ_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tdata  (s_tdata),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
`default_nettype wire

[tb/sv/octree_cell_index_coordinate_map_tb.sv]
`timescale 1ns / 100ps

module octree_cell_index_coordinate_map_tb;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	// level, cell_index, coord_x, coord_y, coord_z, zero pad
	logic [occ_pkg::IN_DATA_W-1:0]     s_tdata = '0;
	// req_type
	logic                              s_tuser = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	// index_out, x_out, y_out, z_out, zero pad
	logic [occ_pkg::OUT_DATA_W-1:0]    m_tdata;
	// out_of_range
	logic                              m_tuser;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [occ_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [occ_pkg::LOG_W-1:0]         cfg_data = '0;

	// Register copy, reset values
	logic [occ_pkg::DIMS_W-1:0] geo_dims = occ_pkg::DIMS_3D;
	logic [occ_pkg::LOG_W-1:0]  geo_bx = '0;
	logic [occ_pkg::LOG_W-1:0]  geo_by = '0;
	logic [occ_pkg::LOG_W-1:0]  geo_bz = '0;

	occ_pkg::res_t predicted_maps[$];
	int unsigned   errors = 0;
	bit            steady = 1'b0;
	int unsigned   stall_left = 0;

	octree_cell_index_coordinate_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[octree_cell_index_coordinate_map] ERROR");
		$finish;
	end

	function automatic logic [63:0] ones(input int unsigned n);
		return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	// Effective grid shape: logs clamped, z folded away unless dims is 3
	function automatic void grid_shape(output bit three, output int unsigned d,
			output int unsigned bx, output int unsigned by, output int unsigned bz);
		three = (geo_dims == occ_pkg::DIMS_3D);
		d = three ? 3 : 2;
		bx = (geo_bx > occ_pkg::MAX_BASE_LOG) ? occ_pkg::MAX_BASE_LOG : geo_bx;
		by = (geo_by > occ_pkg::MAX_BASE_LOG) ? occ_pkg::MAX_BASE_LOG : geo_by;
		bz = !three ? 0 : (geo_bz > occ_pkg::MAX_BASE_LOG) ? occ_pkg::MAX_BASE_LOG : geo_bz;
	endfunction

	// Expected result of one conversion under the current geometry
	function automatic occ_pkg::res_t map_cell(input occ_pkg::req_t req,
			input logic [occ_pkg::LEVEL_W-1:0] lev,
			input logic [occ_pkg::IDX_W-1:0] idx_in,
			input logic [occ_pkg::COORD_W-1:0] cx,
			input logic [occ_pkg::COORD_W-1:0] cy,
			input logic [occ_pkg::COORD_W-1:0] cz);
		bit            three;
		int unsigned   d, bx, by, bz, mb, b;
		logic [63:0]   idx, morton, base, x, y, z, digit;
		occ_pkg::res_t r;
		r = '0;
		grid_shape(three, d, bx, by, bz);
		if (lev > occ_pkg::MAX_LEVEL) begin
			r.oor = 1'b1;
			return r;
		end
		if (req == occ_pkg::REQ_INDEX_TO_COORD) begin
			idx = 64'(idx_in);
			mb = d * lev;
			if ((idx & ~ones(bx + by + bz + mb)) != 0) begin
				r.oor = 1'b1;
				return r;
			end
			morton = idx & ones(mb);
			base = idx >> mb;
			x = (base & ones(bx)) << lev;
			y = ((base >> bx) & ones(by)) << lev;
			z = (base >> (bx + by)) << lev;
			// one Morton digit per level, x in the low bit
			for (b = 0; b < lev; b++) begin
				digit = morton >> (b * d);
				x |= (digit & 64'd1) << b;
				y |= ((digit >> 1) & 64'd1) << b;
				if (three)
					z |= ((digit >> 2) & 64'd1) << b;
			end
			r.x = x[occ_pkg::COORD_W-1:0];
			r.y = y[occ_pkg::COORD_W-1:0];
			r.z = three ? z[occ_pkg::COORD_W-1:0] : '0;
		end else begin
			x = 64'(cx);
			y = 64'(cy);
			z = three ? 64'(cz) : 64'd0;
			if ((x >> (bx + lev)) != 0 || (y >> (by + lev)) != 0 ||
					(z >> (bz + lev)) != 0) begin
				r.oor = 1'b1;
				return r;
			end
			base = (x >> lev) | ((y >> lev) << bx) | ((z >> lev) << (bx + by));
			morton = 0;
			for (b = 0; b < lev; b++) begin
				digit = ((x >> b) & 64'd1) | (((y >> b) & 64'd1) << 1) |
					(((z >> b) & 64'd1) << 2);
				morton |= digit << (b * d);
			end
			idx = (base << (d * lev)) | morton;
			if ((idx >> occ_pkg::IDX_W) != 0) begin
				r.oor = 1'b1;
				return r;
			end
			r.index = idx[occ_pkg::IDX_W-1:0];
		end
		return r;
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Receiver backpressure
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = pick_gap();
			m_tready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		occ_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_maps.size() == 0) begin
				$error("result transfer with nothing outstanding");
				errors++;
			end else begin
				want = predicted_maps.pop_front();
				if (m_tdata[occ_pkg::IDX_W-1:0] !== want.index) begin
					$error("index_out: expected %0h, got %0h", want.index,
						m_tdata[occ_pkg::IDX_W-1:0]);
					errors++;
				end
				if (m_tdata[occ_pkg::IDX_W +: occ_pkg::COORD_W] !== want.x) begin
					$error("x_out: expected %0h, got %0h", want.x,
						m_tdata[occ_pkg::IDX_W +: occ_pkg::COORD_W]);
					errors++;
				end
				if (m_tdata[occ_pkg::IDX_W + occ_pkg::COORD_W +: occ_pkg::COORD_W]
						!== want.y) begin
					$error("y_out: expected %0h, got %0h", want.y,
						m_tdata[occ_pkg::IDX_W + occ_pkg::COORD_W +: occ_pkg::COORD_W]);
					errors++;
				end
				if (m_tdata[occ_pkg::IDX_W + 2 * occ_pkg::COORD_W +: occ_pkg::COORD_W]
						!== want.z) begin
					$error("z_out: expected %0h, got %0h", want.z,
						m_tdata[occ_pkg::IDX_W + 2 * occ_pkg::COORD_W +: occ_pkg::COORD_W]);
					errors++;
				end
				if (m_tuser !== want.oor) begin
					$error("out_of_range: expected %0b, got %0b", want.oor, m_tuser);
					errors++;
				end
			end
		end
	end

	// One input transfer; valid stays up for a back-to-back follower
	task automatic send_item(input occ_pkg::req_t req,
			input logic [occ_pkg::LEVEL_W-1:0] lev,
			input logic [occ_pkg::IDX_W-1:0] idx,
			input logic [occ_pkg::COORD_W-1:0] cx,
			input logic [occ_pkg::COORD_W-1:0] cy,
			input logic [occ_pkg::COORD_W-1:0] cz);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= occ_pkg::IN_DATA_W'({cz, cy, cx, idx, lev});
		do @(posedge clk); while (!s_tready);
		predicted_maps.push_back(map_cell(req, lev, idx, cx, cy, cz));
	endtask

	// Stop the stream and wait for every outstanding result
	task automatic wait_idle();
		int unsigned n;
		n = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (predicted_maps.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (n >= 20000) begin
			$error("results stopped arriving, %0d outstanding", predicted_maps.size());
			errors++;
		end
	endtask

	task automatic write_reg(input occ_pkg::cfg_reg_t which,
			input logic [occ_pkg::LOG_W-1:0] value);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (which)
			occ_pkg::CFG_DIMS:       geo_dims = value[occ_pkg::DIMS_W-1:0];
			occ_pkg::CFG_BASE_LOG_X: geo_bx = value;
			occ_pkg::CFG_BASE_LOG_Y: geo_by = value;
			occ_pkg::CFG_BASE_LOG_Z: geo_bz = value;
			default: ;
		endcase
	endtask

	// Register writes only once the pipe is empty
	task automatic set_geometry(input logic [occ_pkg::LOG_W-1:0] dims_v,
			input logic [occ_pkg::LOG_W-1:0] bx, input logic [occ_pkg::LOG_W-1:0] by,
			input logic [occ_pkg::LOG_W-1:0] bz);
		wait_idle();
		write_reg(occ_pkg::CFG_DIMS, dims_v);
		write_reg(occ_pkg::CFG_BASE_LOG_X, bx);
		write_reg(occ_pkg::CFG_BASE_LOG_Y, by);
		write_reg(occ_pkg::CFG_BASE_LOG_Z, bz);
		cfg_valid <= 1'b0;
	endtask

	// Mostly in-grid requests, some at the boundary, some fully random
	task automatic send_random_item();
		occ_pkg::req_t                 req;
		logic [occ_pkg::LEVEL_W-1:0]   lev;
		logic [occ_pkg::IDX_W-1:0]     idx;
		logic [occ_pkg::COORD_W-1:0]   cx, cy, cz;
		bit                            three;
		int unsigned                   d, bx, by, bz, span, r;
		grid_shape(three, d, bx, by, bz);
		lev = ($urandom_range(0, 99) < 8) ? occ_pkg::LEVEL_W'($urandom_range(11, 15))
			: occ_pkg::LEVEL_W'($urandom_range(0, 10));
		req = occ_pkg::req_t'($urandom_range(0, 1));
		idx = occ_pkg::IDX_W'({$urandom, $urandom});
		cx = occ_pkg::COORD_W'($urandom);
		cy = occ_pkg::COORD_W'($urandom);
		cz = occ_pkg::COORD_W'($urandom);
		r = $urandom_range(0, 99);
		if (req == occ_pkg::REQ_INDEX_TO_COORD) begin
			span = bx + by + bz + d * lev;
			if (r < 75)
				idx &= occ_pkg::IDX_W'(ones(span));
			else if (r < 88 && span < occ_pkg::IDX_W)
				idx = occ_pkg::IDX_W'(ones(span)) + occ_pkg::IDX_W'($urandom_range(0, 1));
		end else begin
			if (r < 80) begin
				cx &= occ_pkg::COORD_W'(ones(bx + lev));
				cy &= occ_pkg::COORD_W'(ones(by + lev));
				if (three)
					cz &= occ_pkg::COORD_W'(ones(bz + lev));
			end else if (r < 90) begin
				cx = occ_pkg::COORD_W'(ones(bx + lev));
				cy = occ_pkg::COORD_W'(ones(by + lev));
				cz = occ_pkg::COORD_W'(ones(bz + lev));
			end
		end
		send_item(req, lev, idx, cx, cy, cz);
	endtask

	// Reset geometry: 3D, one base cell
	task automatic test_reset_geometry();
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd0, '0, '0, '0, '0);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd10, 42'h3FFF_FFFF, '0, '0, '0);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd10, 42'h4000_0000, '0, '0, '0);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd3, '1, '1, '1, '1);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd10, '0, 16'd1023, 16'd1023, 16'd1023);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd10, '0, 16'd1024, '0, '0);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd10, '0, '0, '0, 16'd1024);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd5, '1, 16'h15, 16'h0A, 16'h1F);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd11, '0, '0, '0, '0);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd15, '0, '0, '0, '0);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd0, '0, '0, '0, '0);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd2, '0, '1, '1, '1);
	endtask

	// Largest base grid: index width limit and log saturation
	task automatic test_wide_geometry();
		set_geometry(3'd3, 3'd6, 3'd6, 3'd6);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd10, '0, '1, '1, '1);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd8, '0, 16'h3FFF, 16'h3FFF, 16'h3FFF);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd8, '1, '0, '0, '0);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd10, '1, '0, '0, '0);
		set_geometry(3'd7, 3'd7, 3'd7, 3'd7);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd8, '1, '0, '0, '0);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd8, '0, 16'h4000, '0, '0);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd8, '0, 16'h3FFF, 16'h2AAA, 16'h1555);
	endtask

	// 2D settings, including dims codes below 2
	task automatic test_plane_geometry();
		set_geometry(3'd2, 3'd6, 3'd6, 3'd5);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd10, '0, '1, '1, 16'h1234);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd10, '1, '0, '0, '0);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd10, 42'hFFFF_FFFF, '0, '0, '0);
		set_geometry(3'd4, 3'd0, 3'd3, 3'd7);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd2, '0, 16'd3, 16'd31, '1);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd2, 42'h7F, '0, '0, '0);
		set_geometry(3'd1, 3'd5, 3'd0, 3'd2);
		send_item(occ_pkg::REQ_COORD_TO_INDEX, 4'd1, '0, 16'd63, 16'd2, '0);
		send_item(occ_pkg::REQ_INDEX_TO_COORD, 4'd1, 42'h7F, '0, '0, '0);
	endtask

	// Random geometries with random traffic; one phase runs without idling
	task automatic test_random_geometries();
		int unsigned phase, n;
		logic [occ_pkg::LOG_W-1:0] dims_v;
		for (phase = 0; phase < 8; phase++) begin
			dims_v = ($urandom_range(0, 2) == 0) ? occ_pkg::LOG_W'($urandom_range(0, 7)) :
				occ_pkg::LOG_W'(occ_pkg::DIMS_3D);
			set_geometry(dims_v, occ_pkg::LOG_W'($urandom_range(0, 7)),
				occ_pkg::LOG_W'($urandom_range(0, 7)),
				occ_pkg::LOG_W'($urandom_range(0, 7)));
			steady = (phase == 3);
			for (n = 0; n < 55; n++)
				send_random_item();
			steady = 1'b0;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_wide_geometry();
		test_plane_geometry();
		test_random_geometries();
		wait_idle();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("[octree_cell_index_coordinate_map] OK");
		else
			$display("[octree_cell_index_coordinate_map] ERROR");
		$finish;
	end

endmodule
